/* hw/rtl/primed_moving_average_assert.svh */
// Assertion macros for the checker of the moving-average block.
`ifndef PRIMED_MOVING_AVERAGE_ASSERT_SVH
`define PRIMED_MOVING_AVERAGE_ASSERT_SVH

// Checked on every rising edge of aclk while aresetn is high.
`define PMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define PMA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/pma_pkg.sv */
`default_nettype none

package pma_pkg;

    localparam int SAMPLE_W = 16;

    // Control that every window cell sees in the same cycle.
    typedef struct packed {
        logic shift;   // a beat was accepted: every cell loads
        logic prime;   // first beat after reset: every cell loads the sample
    } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/pma_cell.sv */
`default_nettype none

module pma_cell (
    input  wire                               aclk,
    input  wire  pma_pkg::cell_ctl_t          ctl,
    input  wire  [pma_pkg::SAMPLE_W-1:0]      sample,
    input  wire  [pma_pkg::SAMPLE_W-1:0]      din_left,
    output logic [pma_pkg::SAMPLE_W-1:0]      dout
);

    logic [pma_pkg::SAMPLE_W-1:0] data_reg;
    logic [pma_pkg::SAMPLE_W-1:0] data_next;

    // Priming fills the whole row with the sample; otherwise the row shifts.
    assign data_next = ctl.prime ? sample : din_left;

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/pma_div.sv */
`default_nettype none

// Signed division by a constant, truncating toward zero: magnitude times a
// rounded-up reciprocal, then a shift and the sign restored.
module pma_div #(
    parameter int WINDOW_LENGTH = 8,
    parameter int SUM_W         = 19
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  signed [SUM_W-1:0]           in_sum,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [pma_pkg::SAMPLE_W-1:0]      out_data
);

    localparam int SHIFT   = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int QUOT_W  = PROD_W - SHIFT;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

    logic              prod_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic              out_valid_reg;
    logic [pma_pkg::SAMPLE_W-1:0] out_data_reg;

    logic              out_stage_ready;
    logic              prod_ready;
    logic [SUM_W-1:0]  mag;
    logic [QUOT_W-1:0] quot;
    logic [QUOT_W-1:0] quot_signed;

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign prod_ready      = !prod_valid_reg || out_stage_ready;
    assign in_ready        = prod_ready;

    assign mag  = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
    assign quot = QUOT_W'(prod_reg >> SHIFT);
    assign quot_signed = neg_reg ? QUOT_W'(-quot) : quot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (out_stage_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && prod_ready) begin
            prod_reg <= PROD_W'(mag) * PROD_W'(RECIP);
            neg_reg  <= in_sum[SUM_W-1];
        end
        if (prod_valid_reg && out_stage_ready) begin
            out_data_reg <= quot_signed[pma_pkg::SAMPLE_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/primed_moving_average.sv */
`default_nettype none

// Channel  | Direction | tdata fields (low bit up)     | tuser / tlast
// ---------+-----------+-------------------------------+--------------
// s_       | in        | sample  [15:0] signed         | none
// m_       | out       | average [15:0] signed         | none
//
// One sample beat is taken per cycle while s_tready is high; the running-sum add and
// subtract sets that rate. Each beat gives one average beat, registered first in the window
// row and running sum, then in the reciprocal multiplier and last in the output register.
// Reset is synchronous on aresetn low and clears the primed flag, the running sum and every
// valid bit, so the next beat primes the window again. A stall on m_tready backs up stage by
// stage, and up to three beats may be in flight.

module primed_moving_average #(
    parameter int WINDOW_LENGTH = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // [15:0] average
);

    // The sum of the window needs log2 of its length, rounded up, beyond the sample width.
    localparam int SUM_W = pma_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH);
    localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW_LENGTH);

    logic                        primed_reg;
    logic                        sum_valid_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [SUM_W-1:0]     sum_next;

    logic                        accept;
    logic                        div_ready;
    logic signed [SUM_W-1:0]     sample_ext;
    logic signed [SUM_W-1:0]     oldest_ext;
    pma_pkg::cell_ctl_t          ctl;
    logic [pma_pkg::SAMPLE_W-1:0] cell_q [WINDOW_LENGTH];

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = !sum_valid_reg || div_ready;

    assign ctl.shift  = accept;
    assign ctl.prime  = accept && !primed_reg;

    // The window is a shift row: the newest sample enters the first cell and
    // the last cell always holds the oldest sample, the one that drops out.
    for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
        if (k == 0) begin : g_first
            pma_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .sample   (s_tdata),
                .din_left (s_tdata),
                .dout     (cell_q[k])
            );
        end else begin : g_next
            pma_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .sample   (s_tdata),
                .din_left (cell_q[k-1]),
                .dout     (cell_q[k])
            );
        end
    end

    assign sample_ext = SUM_W'(signed'(s_tdata));
    assign oldest_ext = SUM_W'(signed'(cell_q[WINDOW_LENGTH-1]));

    // The first sample counts once for every entry of the window; after that
    // the sum swaps the oldest sample for the new one.
    always_comb begin
        if (!primed_reg) begin
            sum_next = sample_ext * WIN_S;
        end else begin
            sum_next = sum_reg - oldest_ext + sample_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg    <= 1'b0;
            sum_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end else begin
            if (accept) begin
                primed_reg <= 1'b1;
                sum_reg    <= sum_next;
            end
            if (s_tready) begin
                sum_valid_reg <= s_tvalid;
            end
        end
    end

    pma_div #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SUM_W         (SUM_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid_reg),
        .in_ready  (div_ready),
        .in_sum    (sum_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/pma_checker.sv */
`default_nettype none

`include "primed_moving_average_assert.svh"

module pma_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [15:0] s_tdata,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata
);

    logic        in_beat;
    logic        out_beat;
    logic [2:0]  pending_reg;
    logic [2:0]  pending_next;
    logic        got_first_reg;
    logic        sent_first_reg;
    logic [15:0] first_sample_reg;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (in_beat && !out_beat) begin
            pending_next = pending_reg + 3'd1;
        end else if (out_beat && !in_beat) begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg    <= '0;
            got_first_reg  <= 1'b0;
            sent_first_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            if (in_beat && !got_first_reg) begin
                got_first_reg <= 1'b1;
            end
            if (out_beat) begin
                sent_first_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat && !got_first_reg) begin
            first_sample_reg <= s_tdata;
        end
    end

    `PMA_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !m_tvalid, "result valid right after reset")
    `PMA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `PMA_ASSERT(a_no_extra_result, m_tvalid |-> pending_reg != 3'd0, "result with no sample pending")
    `PMA_ASSERT(a_depth, pending_reg <= 3'd3, "more samples in flight than stages")
    `PMA_ASSERT(a_primed_result, out_beat && !sent_first_reg |-> m_tdata == first_sample_reg, "first average differs from priming sample")

endmodule

bind primed_moving_average pma_checker u_pma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
